### sv/pdms_pkg.sv
`default_nettype none

package pdms_pkg;

	// Grid geometry; the cell size and the grid sides are powers of two.
	localparam int GRID_COLS  = 64;
	localparam int GRID_ROWS  = 64;
	localparam int CELL_SHIFT = 4;
	localparam int CELL_SIZE  = 1 << CELL_SHIFT;
	localparam int CELL_HALF  = CELL_SIZE / 2;
	localparam int COUNT_BITS = 8;

	localparam int COL_W   = $clog2(GRID_COLS);
	localparam int ROW_W   = $clog2(GRID_ROWS);
	localparam int ADDR_W  = COL_W + ROW_W;
	localparam int DEPTH   = GRID_COLS * GRID_ROWS;
	localparam int POS_W   = 13;
	localparam int OFS_W   = 10;
	localparam int THR_W   = 8;
	localparam int PIX_W   = POS_W + 1;
	localparam int COORD_W = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_EVAL  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} command_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X  = 2'd0,
		REG_ORIGIN_Y  = 2'd1,
		REG_THRESHOLD = 2'd2,
		REG_UNUSED    = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		EDGE_TOP    = 2'd0,
		EDGE_RIGHT  = 2'd1,
		EDGE_BOTTOM = 2'd2,
		EDGE_LEFT   = 2'd3
	} edge_t;

	typedef struct packed {
		edge_t a;
		edge_t b;
	} seg_ends_t;

	// Controller to datapath.
	typedef struct packed {
		logic       load;
		logic       add_rd;
		logic       add_wr;
		logic       corner_rd;
		logic [1:0] corner_sel;
		logic       clr_wr;
		logic       out_load;
		logic       seg_sel;
		logic       last;
	} pdms_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic       add_ok;
		logic       ev_ok;
		logic       clr_last;
		logic [1:0] nseg;
	} pdms_sts_t;

	function automatic logic [1:0] seg_count(input logic [3:0] cc);
		logic [1:0] n;
		case (cc)
			4'd0, 4'd15: n = 2'd0;
			4'd5, 4'd10: n = 2'd2;
			default:     n = 2'd1;
		endcase
		return n;
	endfunction

	function automatic seg_ends_t seg_pair(input logic [3:0] cc, input logic sel);
		seg_ends_t s;
		case (cc)
			4'd1:    s = '{EDGE_LEFT, EDGE_BOTTOM};
			4'd2:    s = '{EDGE_BOTTOM, EDGE_RIGHT};
			4'd3:    s = '{EDGE_LEFT, EDGE_RIGHT};
			4'd4:    s = '{EDGE_TOP, EDGE_RIGHT};
			4'd5:    s = sel ? seg_ends_t'{EDGE_BOTTOM, EDGE_RIGHT}
			                 : seg_ends_t'{EDGE_LEFT, EDGE_TOP};
			4'd6:    s = '{EDGE_TOP, EDGE_BOTTOM};
			4'd7:    s = '{EDGE_LEFT, EDGE_TOP};
			4'd8:    s = '{EDGE_LEFT, EDGE_TOP};
			4'd9:    s = '{EDGE_TOP, EDGE_BOTTOM};
			4'd10:   s = sel ? seg_ends_t'{EDGE_LEFT, EDGE_BOTTOM}
			                 : seg_ends_t'{EDGE_TOP, EDGE_RIGHT};
			4'd11:   s = '{EDGE_TOP, EDGE_RIGHT};
			4'd12:   s = '{EDGE_LEFT, EDGE_RIGHT};
			4'd13:   s = '{EDGE_BOTTOM, EDGE_RIGHT};
			4'd14:   s = '{EDGE_LEFT, EDGE_BOTTOM};
			default: s = '{EDGE_TOP, EDGE_TOP};
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

### sv/pdms_datapath.sv
`default_nettype none

module pdms_datapath import pdms_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [OFS_W-1:0]       cfg_data,
	input  wire logic signed [POS_W-1:0] pos_x,
	input  wire logic signed [POS_W-1:0] pos_y,
	input  wire logic [ROW_W-1:0]       cell_row,
	input  wire logic [COL_W-1:0]       cell_col,
	input  wire pdms_cmd_t              cmd,
	output pdms_sts_t                   sts,
	output logic [COORD_W-1:0]          seg_x0,
	output logic [COORD_W-1:0]          seg_y0,
	output logic [COORD_W-1:0]          seg_x1,
	output logic [COORD_W-1:0]          seg_y1,
	output logic [3:0]                  case_code,
	output logic                        last_segment
);

	logic [OFS_W-1:0]      origin_x_q, origin_y_q;
	logic [THR_W-1:0]      thr_q;
	logic [COUNT_BITS-1:0] mem [DEPTH];
	logic [COUNT_BITS-1:0] rd_data_q;
	logic                  rdv_q;
	logic [3:0]            corner_q;
	logic [ADDR_W-1:0]     clr_addr_q;
	logic [ADDR_W-1:0]     add_addr_q;
	logic [ROW_W-1:0]      row_q;
	logic [COL_W-1:0]      col_q;

	logic [PIX_W-1:0]        px, py;
	logic [PIX_W-2-CELL_SHIFT:0] col_full, row_full;
	logic [ADDR_W-1:0]     rd_addr, wr_addr;
	logic [COUNT_BITS-1:0] wr_data;
	logic                  wr_en;
	logic [ROW_W-1:0]      crow;
	logic [COL_W-1:0]      ccol;
	logic [COORD_W-1:0]    base_x, base_y, ax, ay, bx, by;
	seg_ends_t             ends;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			thr_q      <= THR_W'(4);
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X:  origin_x_q <= cfg_data;
				REG_ORIGIN_Y:  origin_y_q <= cfg_data;
				REG_THRESHOLD: thr_q      <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Pixel position of an incoming particle.
	assign px = {pos_x[POS_W-1], pos_x} + {{(PIX_W-OFS_W){1'b0}}, origin_x_q};
	assign py = {{(PIX_W-OFS_W){1'b0}}, origin_y_q} - {pos_y[POS_W-1], pos_y};
	assign col_full = px[PIX_W-2:CELL_SHIFT];
	assign row_full = py[PIX_W-2:CELL_SHIFT];

	assign sts.add_ok = !px[PIX_W-1] && !py[PIX_W-1]
		&& (col_full < ($bits(col_full))'(GRID_COLS))
		&& (row_full < ($bits(row_full))'(GRID_ROWS));
	assign sts.ev_ok = (({1'b0, cell_row} + (ROW_W+1)'(1)) < (ROW_W+1)'(GRID_ROWS))
		&& (({1'b0, cell_col} + (COL_W+1)'(1)) < (COL_W+1)'(GRID_COLS));
	assign sts.clr_last = (clr_addr_q == ADDR_W'(DEPTH - 1));
	assign sts.nseg = seg_count(corner_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			add_addr_q <= {row_full[ROW_W-1:0], col_full[COL_W-1:0]};
			row_q      <= cell_row;
			col_q      <= cell_col;
		end
	end

	// Corner order: top-left, top-right, bottom-right, bottom-left.
	always_comb begin
		crow = row_q;
		ccol = col_q;
		case (cmd.corner_sel)
			2'd1: ccol = col_q + COL_W'(1);
			2'd2: begin
				crow = row_q + ROW_W'(1);
				ccol = col_q + COL_W'(1);
			end
			2'd3: crow = row_q + ROW_W'(1);
			default: ;
		endcase
	end

	assign rd_addr = cmd.corner_rd ? {crow, ccol} : add_addr_q;
	assign wr_en   = cmd.add_wr || cmd.clr_wr;
	assign wr_addr = cmd.clr_wr ? clr_addr_q : add_addr_q;
	assign wr_data = cmd.clr_wr ? '0
		: (rd_data_q == COUNT_MAX) ? rd_data_q : rd_data_q + COUNT_BITS'(1);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_q      <= 1'b0;
			clr_addr_q <= '0;
		end else begin
			rdv_q <= cmd.corner_rd;
			if (cmd.clr_wr)
				clr_addr_q <= sts.clr_last ? '0 : clr_addr_q + ADDR_W'(1);
		end
	end

	// Shift each corner in as its count arrives.
	always_ff @(posedge clk) begin
		if (rdv_q)
			corner_q <= {corner_q[2:0], rd_data_q >= COUNT_BITS'(thr_q)};
	end

	function automatic logic [2*COORD_W-1:0] end_point(input edge_t e,
		input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		logic [COORD_W-1:0] ex, ey;
		case (e)
			EDGE_TOP: begin
				ex = x + COORD_W'(CELL_HALF);
				ey = y;
			end
			EDGE_RIGHT: begin
				ex = x + COORD_W'(CELL_SIZE);
				ey = y + COORD_W'(CELL_HALF);
			end
			EDGE_BOTTOM: begin
				ex = x + COORD_W'(CELL_HALF);
				ey = y + COORD_W'(CELL_SIZE);
			end
			default: begin
				ex = x;
				ey = y + COORD_W'(CELL_HALF);
			end
		endcase
		return {ex, ey};
	endfunction

	assign base_x = COORD_W'({col_q, {CELL_SHIFT{1'b0}}});
	assign base_y = COORD_W'({row_q, {CELL_SHIFT{1'b0}}});
	assign ends   = seg_pair(corner_q, cmd.seg_sel);
	assign {ax, ay} = end_point(ends.a, base_x, base_y);
	assign {bx, by} = end_point(ends.b, base_x, base_y);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			seg_x0       <= ax;
			seg_y0       <= ay;
			seg_x1       <= bx;
			seg_y1       <= by;
			case_code    <= corner_q;
			last_segment <= cmd.last;
		end
	end

endmodule

`default_nettype wire

### sv/pdms_ctrl.sv
`default_nettype none

module pdms_ctrl import pdms_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] command,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire pdms_sts_t  sts,
	output pdms_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_CLEAR,
		ST_EV_RD,
		ST_EV_WAIT,
		ST_EV_CASE,
		ST_SEG
	} state_t;

	state_t     state_q;
	logic [1:0] cnt_q;
	logic       seg_q;
	logic       out_valid_q;
	logic       accept, slot_free;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.load       = accept;
		cmd.add_rd     = (state_q == ST_ADD_RD);
		cmd.add_wr     = (state_q == ST_ADD_WR);
		cmd.clr_wr     = (state_q == ST_CLEAR);
		cmd.corner_rd  = (state_q == ST_EV_RD);
		cmd.corner_sel = cnt_q;
		cmd.seg_sel    = seg_q;
		cmd.last       = seg_q || (sts.nseg == 2'd1);
		cmd.out_load   = (state_q == ST_SEG) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			seg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (command_t'(command))
							CMD_ADD:   if (sts.add_ok) state_q <= ST_ADD_RD;
							CMD_EVAL: begin
								cnt_q <= '0;
								if (sts.ev_ok) state_q <= ST_EV_RD;
							end
							CMD_CLEAR: state_q <= ST_CLEAR;
							default: ;
						endcase
					end
				end
				ST_ADD_RD: state_q <= ST_ADD_WR;
				ST_ADD_WR: state_q <= ST_IDLE;
				ST_CLEAR:  if (sts.clr_last) state_q <= ST_IDLE;
				ST_EV_RD: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) state_q <= ST_EV_WAIT;
				end
				ST_EV_WAIT: state_q <= ST_EV_CASE;
				ST_EV_CASE: begin
					seg_q <= 1'b0;
					state_q <= (sts.nseg == 2'd0) ? ST_IDLE : ST_SEG;
				end
				ST_SEG: begin
					if (slot_free) begin
						if (cmd.last)
							state_q <= ST_IDLE;
						else
							seg_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### sv/particle_density_marching_squares.sv
`default_nettype none

// Particle density grid with marching-squares contour output. The block keeps
// a 64 x 64 grid of 8-bit saturating particle counts in a memory with one
// write and one registered read per cycle. An add request maps the particle's
// world position to a pixel (x plus the x origin register, the y origin
// register minus y), drops it when it falls outside the grid and otherwise
// increments the count of its 16-pixel cell. A kept add occupies the block
// from its accept cycle to the next accept (accept, read, write back); a
// dropped add leaves the block idle. An evaluate request names the top-left
// corner of a cell; the four corner counts are read one per cycle and compared
// with the threshold register; the resulting case code yields zero, one or
// two segments between edge midpoints. Evaluate steps through accept, four
// reads, one step to take in the last count and one to form the case, then
// hands out each segment in turn, stalling while the result register waits
// on out_ready. A cell on the last row or column leaves the block idle. Such a
// cell, a cell whose four corners are all inside or all outside, and the
// unused command give no result. A clear request zeroes the grid with one
// memory write per cycle; the same clearing pass runs right after reset, and
// in_ready stays low during it. Configuration writes take effect at once and
// are expected only while the block is idle; in_ready is high whenever the
// block is waiting for a request, even while a finished segment still waits.
module particle_density_marching_squares import pdms_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_write,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [OFS_W-1:0]        cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [1:0]              command,
	input  wire logic signed [POS_W-1:0] pos_x,
	input  wire logic signed [POS_W-1:0] pos_y,
	input  wire logic [ROW_W-1:0]        cell_row,
	input  wire logic [COL_W-1:0]        cell_col,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [COORD_W-1:0]           seg_x0,
	output logic [COORD_W-1:0]           seg_y0,
	output logic [COORD_W-1:0]           seg_x1,
	output logic [COORD_W-1:0]           seg_y1,
	output logic [3:0]                   case_code,
	output logic                         last_segment
);

	pdms_cmd_t cmd;
	pdms_sts_t sts;

	// Sequence each request: accept, memory access steps, segment hand-off.
	pdms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold the count memory, the registers and the segment geometry.
	pdms_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.cell_row     (cell_row),
		.cell_col     (cell_col),
		.cmd          (cmd),
		.sts          (sts),
		.seg_x0       (seg_x0),
		.seg_y0       (seg_y0),
		.seg_x1       (seg_x1),
		.seg_y1       (seg_y1),
		.case_code    (case_code),
		.last_segment (last_segment)
	);

endmodule

`default_nettype wire

### dv/particle_density_marching_squares_tb.sv
`timescale 1ns / 1ps

module particle_density_marching_squares_tb;

	import pdms_pkg::*;

	// One contour segment as the block reports it.
	typedef struct packed {
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
		logic [3:0]         code;
		logic               last;
	} segment_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = REG_ORIGIN_X;
	logic [OFS_W-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [1:0]              command = CMD_NONE;
	logic signed [POS_W-1:0] pos_x = '0;
	logic signed [POS_W-1:0] pos_y = '0;
	logic [ROW_W-1:0]        cell_row = '0;
	logic [COL_W-1:0]        cell_col = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [COORD_W-1:0]      seg_x0;
	logic [COORD_W-1:0]      seg_y0;
	logic [COORD_W-1:0]      seg_x1;
	logic [COORD_W-1:0]      seg_y1;
	logic [3:0]              case_code;
	logic                    last_segment;

	// Shadow of the block: density grid and the three registers.
	logic [COUNT_BITS-1:0] density_model [DEPTH];
	int model_origin_x = 0;
	int model_origin_y = 0;
	int model_threshold = 4;

	// Segments still owed by the block, oldest first.
	segment_t pending_segments [$];

	// Idling knobs: stall chances in percent per request or per cycle, and a hold length.
	int src_stall_pct = 0;
	int sink_stall_pct = 0;
	int sink_hold_request = 0;

	int error_count = 0;
	int requests_sent = 0;
	int clears_sent = 0;
	int segments_checked = 0;
	logic [15:0] cases_seen = '0;

	particle_density_marching_squares dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.cell_row     (cell_row),
		.cell_col     (cell_col),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.seg_x0       (seg_x0),
		.seg_y0       (seg_y0),
		.seg_x1       (seg_x1),
		.seg_y1       (seg_y1),
		.case_code    (case_code),
		.last_segment (last_segment)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_length();
		return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(12, 40);
	endfunction

	// A corner is inside once its count reaches the threshold.
	function automatic logic corner_set(input int r, input int c);
		return density_model[r * GRID_COLS + c] >= model_threshold;
	endfunction

	// Edge pair {start, end} for a corner pattern; the two-segment saddles
	// pick their second segment with 'second'.
	function automatic logic [3:0] contour_edges(input logic [3:0] code, input logic second);
		case (code)
		4'd1:    return {EDGE_LEFT, EDGE_BOTTOM};
		4'd2:    return {EDGE_BOTTOM, EDGE_RIGHT};
		4'd3:    return {EDGE_LEFT, EDGE_RIGHT};
		4'd4:    return {EDGE_TOP, EDGE_RIGHT};
		4'd5:    return second ? {EDGE_BOTTOM, EDGE_RIGHT} : {EDGE_LEFT, EDGE_TOP};
		4'd6:    return {EDGE_TOP, EDGE_BOTTOM};
		4'd7:    return {EDGE_LEFT, EDGE_TOP};
		4'd8:    return {EDGE_LEFT, EDGE_TOP};
		4'd9:    return {EDGE_TOP, EDGE_BOTTOM};
		4'd10:   return second ? {EDGE_LEFT, EDGE_BOTTOM} : {EDGE_TOP, EDGE_RIGHT};
		4'd11:   return {EDGE_TOP, EDGE_RIGHT};
		4'd12:   return {EDGE_LEFT, EDGE_RIGHT};
		4'd13:   return {EDGE_BOTTOM, EDGE_RIGHT};
		4'd14:   return {EDGE_LEFT, EDGE_BOTTOM};
		default: return {EDGE_TOP, EDGE_TOP};
		endcase
	endfunction

	// Midpoint pixel {x, y} of one side of the cell whose top-left pixel is (x, y).
	function automatic logic [2*COORD_W-1:0] edge_midpoint(input edge_t side, input int x,
			input int y);
		logic [COORD_W-1:0] mx;
		logic [COORD_W-1:0] my;
		case (side)
		EDGE_TOP: begin
			mx = COORD_W'(x + CELL_SIZE / 2);
			my = COORD_W'(y);
		end
		EDGE_RIGHT: begin
			mx = COORD_W'(x + CELL_SIZE);
			my = COORD_W'(y + CELL_SIZE / 2);
		end
		EDGE_BOTTOM: begin
			mx = COORD_W'(x + CELL_SIZE / 2);
			my = COORD_W'(y + CELL_SIZE);
		end
		default: begin
			mx = COORD_W'(x);
			my = COORD_W'(y + CELL_SIZE / 2);
		end
		endcase
		return {mx, my};
	endfunction

	// Advance the shadow grid by one accepted request and queue the segments
	// it owes.
	task automatic predict_request(input command_t cmd, input logic signed [POS_W-1:0] wx,
			input logic signed [POS_W-1:0] wy, input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		int px;
		int py;
		int r;
		int c;
		int addr;
		int nseg;
		logic [3:0] code;
		logic [3:0] ends;
		segment_t seg;
		case (cmd)
		CMD_ADD: begin
			px = wx;
			px = px + model_origin_x;
			py = wy;
			py = model_origin_y - py;
			// Drop particles left of or above the grid, or beyond its far sides.
			if (px >= 0 && py >= 0 && px / CELL_SIZE < GRID_COLS && py / CELL_SIZE < GRID_ROWS) begin
				addr = (py / CELL_SIZE) * GRID_COLS + px / CELL_SIZE;
				if (density_model[addr] != COUNT_MAX)
					density_model[addr] = density_model[addr] + 1'b1;
			end
		end
		CMD_CLEAR: begin
			foreach (density_model[i])
				density_model[i] = '0;
		end
		CMD_EVAL: begin
			r = row;
			c = col;
			// A cell needs its right and bottom neighbors inside the grid.
			if (r < GRID_ROWS - 1 && c < GRID_COLS - 1) begin
				code = {corner_set(r, c), corner_set(r, c + 1), corner_set(r + 1, c + 1),
					corner_set(r + 1, c)};
				if (code == 4'd0 || code == 4'd15)
					nseg = 0;
				else if (code == 4'd5 || code == 4'd10)
					nseg = 2;
				else
					nseg = 1;
				for (int k = 0; k < nseg; k++) begin
					ends = contour_edges(code, k == 1);
					{seg.x0, seg.y0} = edge_midpoint(edge_t'(ends[3:2]), c * CELL_SIZE, r * CELL_SIZE);
					{seg.x1, seg.y1} = edge_midpoint(edge_t'(ends[1:0]), c * CELL_SIZE, r * CELL_SIZE);
					seg.code = code;
					seg.last = (k == nseg - 1);
					pending_segments.push_back(seg);
				end
			end
		end
		default: ;
		endcase
	endtask

	// Offer one request and hold it until the block takes it. Valid stays
	// high afterwards so that a following request can go out back to back.
	// Fields are cut down to their port widths here.
	task automatic send_request(input command_t cmd, input int wx, input int wy,
			input int row, input int col);
		logic signed [POS_W-1:0] req_x;
		logic signed [POS_W-1:0] req_y;
		logic [ROW_W-1:0]        req_row;
		logic [COL_W-1:0]        req_col;
		req_x = POS_W'(wx);
		req_y = POS_W'(wy);
		req_row = ROW_W'(row);
		req_col = COL_W'(col);
		if (src_stall_pct > 0 && $urandom_range(0, 99) < src_stall_pct) begin
			in_valid <= 1'b0;
			repeat (gap_length()) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		pos_x <= req_x;
		pos_y <= req_y;
		cell_row <= req_row;
		cell_col <= req_col;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		predict_request(cmd, req_x, req_y, req_row, req_col);
		if (cmd != CMD_NONE)
			requests_sent++;
		if (cmd == CMD_CLEAR)
			clears_sent++;
	endtask

	// Drop valid and wait until every owed segment has come out.
	task automatic hold_requests_until_drained();
		in_valid <= 1'b0;
		while (pending_segments.size() != 0) @(posedge clk);
	endtask

	// Bring the block to rest before a register write: adds and clears owe
	// nothing, so give them time to start and then wait for in_ready.
	task automatic settle_block();
		hold_requests_until_drained();
		repeat (8) @(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [OFS_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		case (idx)
		REG_ORIGIN_X:  model_origin_x = data;
		REG_ORIGIN_Y:  model_origin_y = data;
		REG_THRESHOLD: model_threshold = data[THR_W-1:0];
		default: ;
		endcase
	endtask

	// Drop one particle somewhere inside grid cell (row, col) under the
	// current origin.
	task automatic add_particle_at(input int row, input int col);
		int px;
		int py;
		px = col * CELL_SIZE + $urandom_range(0, CELL_SIZE - 1);
		py = row * CELL_SIZE + $urandom_range(0, CELL_SIZE - 1);
		send_request(CMD_ADD, px - model_origin_x, model_origin_y - py,
			$urandom_range(0, GRID_ROWS - 1), $urandom_range(0, GRID_COLS - 1));
	endtask

	// Build a chosen corner pattern around cell (row, col), then evaluate it.
	// Corners left outside get fewer particles than the corners set in the mask.
	task automatic send_contour_cell(input int row, input int col);
		int dr[4] = '{0, 0, 1, 1};
		int dc[4] = '{0, 1, 1, 0};
		logic [3:0] mask;
		int fill;
		int n;
		mask = 4'($urandom_range(0, 15));
		fill = (model_threshold > 6) ? 6 : model_threshold;
		for (int i = 0; i < 4; i++) begin
			if (mask[3 - i])
				n = fill;
			else
				n = (fill > 1) ? $urandom_range(0, fill - 1) : 0;
			repeat (n) add_particle_at(row + dr[i], col + dc[i]);
		end
		send_request(CMD_EVAL, $urandom, $urandom, row, col);
	endtask

	// Anything the fields allow: far-off and near-grid adds, evaluates of any
	// cell, the unused command and the occasional clear.
	task automatic send_noise_request();
		int pick;
		logic [31:0] rx;
		logic [31:0] ry;
		pick = $urandom_range(0, 199);
		rx = $urandom;
		ry = $urandom;
		if (pick < 50)
			send_request(CMD_ADD, rx[POS_W-1:0], ry[POS_W-1:0], rx[20:15], ry[20:15]);
		else if (pick < 100)
			send_request(CMD_ADD, $urandom_range(0, 2400) - 1200, $urandom_range(0, 2400) - 1200,
				rx[20:15], ry[20:15]);
		else if (pick < 170)
			send_request(CMD_EVAL, rx[POS_W-1:0], ry[POS_W-1:0], rx[20:15], ry[20:15]);
		else if (pick < 197)
			send_request(CMD_NONE, rx[POS_W-1:0], ry[POS_W-1:0], rx[20:15], ry[20:15]);
		else
			send_request(CMD_CLEAR, rx[POS_W-1:0], ry[POS_W-1:0], rx[20:15], ry[20:15]);
	endtask

	task automatic check_field(input string name, input logic [COORD_W-1:0] want,
			input logic [COORD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	// Result side: hold out_ready low for a requested stretch, otherwise
	// stall at random at the current rate.
	initial begin : result_sink
		int gap_left;
		int hold_left;
		gap_left = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold_request > 0) begin
				hold_left = sink_hold_request;
				sink_hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				out_ready <= 1'b0;
			end else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct) begin
				gap_left = gap_length() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare every segment the block hands over with the oldest one owed.
	always @(posedge clk) begin : segment_checker
		segment_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pending_segments.size() == 0) begin
				$display("%0t: segment with none owed, expected nothing, got (%0d,%0d)-(%0d,%0d) case %0d",
					$time, seg_x0, seg_y0, seg_x1, seg_y1, case_code);
				error_count++;
			end else begin
				want = pending_segments.pop_front();
				check_field("seg_x0", want.x0, seg_x0);
				check_field("seg_y0", want.y0, seg_y0);
				check_field("seg_x1", want.x1, seg_x1);
				check_field("seg_y1", want.y1, seg_y1);
				check_field("case_code", COORD_W'(want.code), COORD_W'(case_code));
				check_field("last_segment", COORD_W'(want.last), COORD_W'(last_segment));
				segments_checked++;
				cases_seen[want.code] = 1'b1;
			end
		end
	end

	// Reset registers, extreme positions, last row and column, unused command.
	task automatic test_defaults_and_extremes();
		// Far corners of the position range all land off the grid.
		send_request(CMD_ADD, -4096, 4095, 0, 0);
		send_request(CMD_ADD, 4095, -4096, 0, 0);
		send_request(CMD_ADD, 4095, 4095, 0, 0);
		send_request(CMD_ADD, -4096, -4096, 0, 0);
		// With a zero origin, world (x, -y) is pixel (x, y); the reset
		// threshold is four.
		repeat (2) send_request(CMD_ADD, 0, 0, 0, 0);
		repeat (2) send_request(CMD_ADD, 15, -15, 0, 0);
		repeat (3) send_request(CMD_ADD, 16, -1, 0, 0);
		send_request(CMD_EVAL, 0, 0, 0, 0);
		send_request(CMD_ADD, 31, -15, 0, 0);
		send_request(CMD_EVAL, 0, 0, 0, 0);
		send_request(CMD_NONE, -1, -1, 63, 63);
		// Last row and last column have no cell below or right of them.
		send_request(CMD_EVAL, 0, 0, 63, 0);
		send_request(CMD_EVAL, 0, 0, 0, 63);
		send_request(CMD_EVAL, 0, 0, 63, 63);
		// Farthest pixel still on the grid.
		send_request(CMD_ADD, 1023, -1023, 0, 0);
		send_request(CMD_EVAL, 0, 0, 62, 62);
	endtask

	// Both saddle patterns, under an extreme origin and a threshold of one.
	task automatic test_saddle_cells();
		settle_block();
		write_register(REG_ORIGIN_X, 10'h3FF);
		write_register(REG_ORIGIN_Y, 10'h3FF);
		write_register(REG_THRESHOLD, 10'd1);
		send_request(CMD_CLEAR, 0, 0, 0, 0);
		add_particle_at(5, 6);
		add_particle_at(6, 5);
		send_request(CMD_EVAL, 0, 0, 5, 5);
		add_particle_at(10, 10);
		add_particle_at(11, 11);
		send_request(CMD_EVAL, 0, 0, 10, 10);
		send_request(CMD_EVAL, 0, 0, 9, 9);
	endtask

	// Unused register index must change nothing; a zero threshold puts
	// every corner inside.
	task automatic test_register_corners();
		settle_block();
		write_register(REG_UNUSED, 10'h3FF);
		add_particle_at(20, 21);
		send_request(CMD_EVAL, 0, 0, 20, 20);
		settle_block();
		write_register(REG_THRESHOLD, 10'h300);
		send_request(CMD_EVAL, 0, 0, 20, 20);
		send_request(CMD_EVAL, 0, 0, 40, 7);
		settle_block();
		write_register(REG_THRESHOLD, 10'h101);
		send_request(CMD_EVAL, 0, 0, 20, 20);
	endtask

	// Push one count to the top and past it under the highest threshold.
	task automatic test_saturation();
		settle_block();
		write_register(REG_ORIGIN_X, 10'd0);
		write_register(REG_ORIGIN_Y, 10'd0);
		write_register(REG_THRESHOLD, 10'hFF);
		send_request(CMD_CLEAR, 0, 0, 0, 0);
		repeat (254) add_particle_at(20, 20);
		send_request(CMD_EVAL, 0, 0, 20, 20);
		add_particle_at(20, 20);
		send_request(CMD_EVAL, 0, 0, 20, 20);
		repeat (10) add_particle_at(20, 20);
		send_request(CMD_EVAL, 0, 0, 20, 20);
		send_request(CMD_EVAL, 0, 0, 19, 19);
	endtask

	// Stall the result side long enough for the block to back up into its
	// input, then pause the sender until everything has drained.
	task automatic test_backpressure();
		int saved_src;
		settle_block();
		write_register(REG_THRESHOLD, 10'd1);
		send_request(CMD_CLEAR, 0, 0, 0, 0);
		for (int c = 28; c < 44; c += 2)
			add_particle_at(30, c);
		saved_src = src_stall_pct;
		src_stall_pct = 0;
		sink_hold_request = 300;
		// Every one of these cells touches exactly one occupied row.
		for (int c = 28; c < 44; c++) begin
			send_request(CMD_EVAL, 0, 0, 29, c);
			send_request(CMD_EVAL, 0, 0, 30, c);
		end
		hold_requests_until_drained();
		for (int c = 28; c < 36; c++)
			send_request(CMD_EVAL, 0, 0, 29, c);
		src_stall_pct = saved_src;
	endtask

	// Random phases, each under its own register setting and idling mix.
	// Most traffic builds corner patterns and evaluates them; the rest is noise.
	task automatic test_random_contours();
		int phase_end;
		int thr;
		logic [1:0] thr_hi;
		for (int phase = 0; phase < 6; phase++) begin
			settle_block();
			thr_hi = 2'($urandom_range(0, 3));
			case (phase)
			0: begin
				write_register(REG_ORIGIN_X, 10'd0);
				write_register(REG_ORIGIN_Y, 10'h3FF);
				thr = 1;
			end
			1: begin
				write_register(REG_ORIGIN_X, 10'h3FF);
				write_register(REG_ORIGIN_Y, 10'd0);
				thr = 2;
			end
			2: begin
				write_register(REG_ORIGIN_X, OFS_W'($urandom_range(0, 1023)));
				write_register(REG_ORIGIN_Y, OFS_W'($urandom_range(0, 1023)));
				thr = 255;
			end
			default: begin
				write_register(REG_ORIGIN_X, OFS_W'($urandom_range(0, 1023)));
				write_register(REG_ORIGIN_Y, OFS_W'($urandom_range(0, 1023)));
				thr = $urandom_range(1, 6);
			end
			endcase
			write_register(REG_THRESHOLD, {thr_hi, 8'(thr)});
			// Vary idling per phase; some phases run without source gaps, some without sink gaps.
			src_stall_pct = (phase % 3 == 0) ? 0 : $urandom_range(10, 50);
			sink_stall_pct = (phase % 3 == 1) ? 0 : $urandom_range(10, 50);
			if (phase % 2 == 0)
				send_request(CMD_CLEAR, 0, 0, 0, 0);
			phase_end = requests_sent + 275;
			while (requests_sent < phase_end) begin
				if ($urandom_range(0, 99) < 70)
					send_contour_cell($urandom_range(0, GRID_ROWS - 2),
						$urandom_range(0, GRID_COLS - 2));
				else
					send_noise_request();
				if ($urandom_range(0, 99) < 2)
					hold_requests_until_drained();
			end
		end
		src_stall_pct = 0;
		sink_stall_pct = 0;
	endtask

	initial begin : stimulus
		foreach (density_model[i])
			density_model[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		src_stall_pct = 20;
		sink_stall_pct = 20;
		test_defaults_and_extremes();
		test_saddle_cells();
		test_register_corners();
		test_saturation();
		test_backpressure();
		test_random_contours();
		settle_block();
		repeat (20) @(posedge clk);
		$display("Sent %0d requests (%0d grid clears); checked %0d segments.",
			requests_sent, clears_sent, segments_checked);
		$display("Saw %0d of 14 segment-bearing corner patterns; %0d mismatches.",
			$countones(cases_seen), error_count);
		if (error_count == 0 && pending_segments.size() == 0)
			$display("particle_density_marching_squares verification clean");
		else
			$display("particle_density_marching_squares verification failed");
		$finish;
	end

	// Generous cap on simulated time.
	initial begin : watchdog
		#10_000_000;
		$display("particle_density_marching_squares verification failed");
		$finish;
	end

endmodule

### particle_density_marching_squares.f
sv/pdms_pkg.sv
sv/pdms_datapath.sv
sv/pdms_ctrl.sv
sv/particle_density_marching_squares.sv
dv/particle_density_marching_squares_tb.sv
